// ===== rtl/abre_pkg.sv =====
// Shared constants, codes and controller/datapath signal groups for the range encoder.
package abre_pkg;

	localparam int PROB_ENTRIES_DEF = 8192;
	localparam int PROB_BITS_DEF    = 11;
	localparam int ADAPT_SHIFT_DEF  = 5;

	localparam int CMD_W     = 2;
	localparam int PIDX_W    = 13;
	localparam int DVAL_W    = 26;
	localparam int DCNT_W    = 5;
	localparam int BYTE_W    = 8;
	localparam int FCNT_W    = 32;
	localparam int LOW_W     = 33;
	localparam int RANGE_W   = 32;

	localparam logic [DCNT_W-1:0] DIRECT_MAX   = 5'd26;
	localparam logic [DCNT_W-1:0] FLUSH_SHIFTS = 5'd5;

	typedef enum logic [CMD_W-1:0] {
		CMD_BIT    = 2'd0,
		CMD_DIRECT = 2'd1,
		CMD_FLUSH  = 2'd2,
		CMD_START  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic accept;
		logic init;
		logic clr_wr;
		logic rd;
		logic mul;
		logic upd;
		logic dir_step;
		logic cnt_dec;
		logic shift;
		logic shift_range;
		logic flush_last;
	} ctl_t;

	typedef struct packed {
		logic need_norm;
		logic emits;
		logic out_free;
		logic cnt_zero;
		logic cnt_one;
		logic clr_last;
	} sts_t;

endpackage

// ===== rtl/abre_in_if.sv =====
// Input channel: one coding command word with valid/ready.
interface abre_in_if;
	logic                            valid;
	logic                            ready;
	logic [abre_pkg::CMD_W-1:0]      cmd;
	logic [abre_pkg::PIDX_W-1:0]     prob_index;
	logic                            bit_value;
	logic [abre_pkg::DVAL_W-1:0]     direct_value;
	logic [abre_pkg::DCNT_W-1:0]     direct_count;

	modport source (output valid, cmd, prob_index, bit_value, direct_value, direct_count,
		input ready);
	modport sink (input valid, cmd, prob_index, bit_value, direct_value, direct_count,
		output ready);
endinterface

// ===== rtl/abre_out_if.sv =====
// Output channel: one lead byte plus fill run word with valid/ready.
interface abre_out_if;
	logic                            valid;
	logic                            ready;
	logic [abre_pkg::BYTE_W-1:0]     lead_byte;
	logic [abre_pkg::BYTE_W-1:0]     fill_byte;
	logic [abre_pkg::FCNT_W-1:0]     fill_count;
	logic                            flush_done;

	modport source (output valid, lead_byte, fill_byte, fill_count, flush_done, input ready);
	modport sink (input valid, lead_byte, fill_byte, fill_count, flush_done, output ready);
endinterface

// ===== rtl/abre_dp.sv =====
// Range coder datapath: coder state, probability memory, multiplier and output register.
module abre_dp #(
	parameter int PROB_ENTRIES = abre_pkg::PROB_ENTRIES_DEF,
	parameter int PROB_BITS    = abre_pkg::PROB_BITS_DEF,
	parameter int ADAPT_SHIFT  = abre_pkg::ADAPT_SHIFT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  abre_pkg::ctl_t                  ctl,
	output abre_pkg::sts_t                  sts,
	input  logic [abre_pkg::CMD_W-1:0]      cmd,
	input  logic [abre_pkg::PIDX_W-1:0]     prob_index,
	input  logic                            bit_value,
	input  logic [abre_pkg::DVAL_W-1:0]     direct_value,
	input  logic [abre_pkg::DCNT_W-1:0]     direct_count,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [abre_pkg::BYTE_W-1:0]     lead_byte,
	output logic [abre_pkg::BYTE_W-1:0]     fill_byte,
	output logic [abre_pkg::FCNT_W-1:0]     fill_count,
	output logic                            flush_done
);

	localparam int IDX_W     = $clog2(PROB_ENTRIES);
	localparam int RED_STEPS = 7;
	localparam logic [31:0] ENTRIES_V = 32'(PROB_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PROB_ENTRIES - 1);
	localparam logic [PROB_BITS:0] PROB_TOTAL = {1'b1, {PROB_BITS{1'b0}}};
	localparam logic [PROB_BITS-1:0] PROB_HALF = {1'b1, {(PROB_BITS-1){1'b0}}};
	localparam int RW = abre_pkg::RANGE_W;
	localparam int LW = abre_pkg::LOW_W;
	localparam int BW = abre_pkg::BYTE_W;
	localparam int FW = abre_pkg::FCNT_W;
	localparam int CW = abre_pkg::DCNT_W;

	logic [PROB_BITS-1:0]        mem [PROB_ENTRIES];
	logic [PROB_BITS-1:0]        rdata_q;
	logic [IDX_W-1:0]            idx_q;
	logic [IDX_W-1:0]            clr_q;
	logic                        bit_q;
	logic [abre_pkg::DVAL_W-1:0] dval_q;
	logic [CW-1:0]               cnt_q;
	logic [RW-1:0]               bound_q;
	logic [LW-1:0]               low_q;
	logic [RW-1:0]               range_q;
	logic [BW-1:0]               cache_q;
	logic [FW-1:0]               pend_q;
	logic                        out_valid_q;
	logic [BW-1:0]               lead_q;
	logic [BW-1:0]               fill_q;
	logic [FW-1:0]               fcnt_q;
	logic                        fdone_q;

	logic [IDX_W-1:0]            idx_next;
	logic [CW-1:0]               cnt_next;
	logic [RW-PROB_BITS-1:0]     rng_hi;
	logic [RW-1:0]               prod;
	logic [PROB_BITS:0]          p_diff;
	logic [PROB_BITS:0]          p_sum;
	logic [PROB_BITS-1:0]        p_new;
	logic [RW-1:0]               rng_half;
	logic [CW-1:0]               bit_sel;
	logic                        dbit;
	logic                        carry;
	logic                        emits;

	// index modulo the store depth by restoring subtraction (quotient below 128)
	always_comb begin
		logic [31:0] v;
		v = {{(32-abre_pkg::PIDX_W){1'b0}}, prob_index};
		for (int k = RED_STEPS - 1; k >= 0; k--) begin
			if (v >= (ENTRIES_V << k))
				v = v - (ENTRIES_V << k);
		end
		idx_next = v[IDX_W-1:0];
	end

	always_comb begin
		case (abre_pkg::cmd_t'(cmd))
			abre_pkg::CMD_DIRECT:
				cnt_next = (direct_count > abre_pkg::DIRECT_MAX) ? abre_pkg::DIRECT_MAX
					: direct_count;
			abre_pkg::CMD_FLUSH: cnt_next = abre_pkg::FLUSH_SHIFTS;
			default: cnt_next = '0;
		endcase
	end

	assign rng_hi = range_q[RW-1:PROB_BITS];
	assign prod   = RW'(rng_hi) * RW'(rdata_q);

	always_comb begin
		p_diff = PROB_TOTAL - {1'b0, rdata_q};
		if (!bit_q) begin
			p_sum = {1'b0, rdata_q} + (p_diff >> ADAPT_SHIFT);
			p_new = p_sum[PROB_BITS-1:0];
		end else begin
			p_sum = '0;
			p_new = rdata_q - (rdata_q >> ADAPT_SHIFT);
		end
	end

	assign rng_half = {1'b0, range_q[RW-1:1]};
	assign bit_sel  = cnt_q - CW'(1);
	assign dbit     = dval_q[bit_sel];

	assign carry = low_q[LW-1];
	assign emits = carry | (low_q[RW-1:RW-BW] != {BW{1'b1}});

	assign sts.need_norm = (range_q[RW-1:RW-BW] == '0);
	assign sts.emits     = emits;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.cnt_one   = (cnt_q == CW'(1));
	assign sts.clr_last  = (clr_q == LAST_IDX);

	// probability store: one write port shared by the clearing pass and adaptation
	always_ff @(posedge clk) begin
		if (ctl.clr_wr)
			mem[clr_q] <= PROB_HALF;
		else if (ctl.upd)
			mem[idx_q] <= p_new;
		if (ctl.rd)
			rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			idx_q  <= idx_next;
			bit_q  <= bit_value;
			dval_q <= direct_value;
		end
		if (ctl.mul)
			bound_q <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			if (ctl.accept)
				cnt_q <= cnt_next;
			else if (ctl.cnt_dec)
				cnt_q <= cnt_q - CW'(1);
			if (ctl.init)
				clr_q <= '0;
			else if (ctl.clr_wr)
				clr_q <= clr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '0;
			range_q <= '1;
			cache_q <= '0;
			pend_q  <= FW'(1);
		end else if (ctl.init) begin
			low_q   <= '0;
			range_q <= '1;
			cache_q <= '0;
			pend_q  <= FW'(1);
		end else if (ctl.upd) begin
			if (!bit_q) begin
				range_q <= bound_q;
			end else begin
				low_q   <= low_q + {1'b0, bound_q};
				range_q <= range_q - bound_q;
			end
		end else if (ctl.dir_step) begin
			range_q <= rng_half;
			if (dbit)
				low_q <= low_q + {1'b0, rng_half};
		end else if (ctl.shift) begin
			if (ctl.shift_range)
				range_q <= {range_q[RW-BW-1:0], {BW{1'b0}}};
			low_q <= {1'b0, low_q[RW-BW-1:0], {BW{1'b0}}};
			if (emits) begin
				cache_q <= low_q[RW-1:RW-BW];
				pend_q  <= FW'(1);
			end else if (pend_q != {FW{1'b1}}) begin
				pend_q <= pend_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.shift && emits)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.shift && emits) begin
			lead_q  <= cache_q + BW'(carry);
			fill_q  <= carry ? {BW{1'b0}} : {BW{1'b1}};
			fcnt_q  <= (pend_q == '0) ? '0 : pend_q - FW'(1);
			fdone_q <= ctl.flush_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign lead_byte  = lead_q;
	assign fill_byte  = fill_q;
	assign fill_count = fcnt_q;
	assign flush_done = fdone_q;

endmodule

// ===== rtl/abre_ctrl.sv =====
// Range coder controller: sequences clearing, modeled, direct and flush operations.
module abre_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [abre_pkg::CMD_W-1:0]  in_cmd,
	output logic                        in_ready,
	input  abre_pkg::sts_t              sts,
	output abre_pkg::ctl_t              ctl
);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b00000001,
		ST_IDLE  = 8'b00000010,
		ST_READ  = 8'b00000100,
		ST_MUL   = 8'b00001000,
		ST_UPD   = 8'b00010000,
		ST_NORM  = 8'b00100000,
		ST_DIR   = 8'b01000000,
		ST_FLUSH = 8'b10000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					case (abre_pkg::cmd_t'(in_cmd))
						abre_pkg::CMD_BIT:    state_d = ST_READ;
						abre_pkg::CMD_DIRECT: state_d = ST_DIR;
						abre_pkg::CMD_FLUSH:  state_d = ST_FLUSH;
						abre_pkg::CMD_START: begin
							ctl.init = 1'b1;
							state_d  = ST_CLEAR;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: begin
				ctl.rd  = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				ctl.upd = 1'b1;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				if (!sts.need_norm) begin
					state_d = sts.cnt_zero ? ST_IDLE : ST_DIR;
				end else if (!sts.emits || sts.out_free) begin
					ctl.shift       = 1'b1;
					ctl.shift_range = 1'b1;
					state_d         = sts.cnt_zero ? ST_IDLE : ST_DIR;
				end
			end
			ST_DIR: begin
				if (sts.cnt_zero) begin
					state_d = ST_IDLE;
				end else begin
					ctl.dir_step = 1'b1;
					ctl.cnt_dec  = 1'b1;
					state_d      = ST_NORM;
				end
			end
			ST_FLUSH: begin
				if (sts.cnt_zero) begin
					state_d = ST_IDLE;
				end else if (!sts.emits || sts.out_free) begin
					ctl.shift      = 1'b1;
					ctl.cnt_dec    = 1'b1;
					ctl.flush_last = sts.cnt_one;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/adaptive_binary_range_encoder.sv =====
// Adaptive binary range encoder top level: controller plus datapath on word channels.
// Each input word is one command: code a modeled bit against an adaptive probability,
// code 0 to 26 direct bits (larger counts clamp to 26), flush, or start a new stream.
// A modeled bit steps through accept, probability read, multiply, update, renormalize;
// each direct bit takes a step and a renormalize, and a flush makes FLUSH_SHIFTS shifts.
// Renormalize and flush shifts stall while the output register holds an untaken word
// and a byte must leave. Start and reset clear all PROB_ENTRIES probability entries,
// one entry per cycle, during which no word is accepted. Each output word is a lead
// byte followed by fill_count fill bytes; flush_done marks the last word of a flush.
module adaptive_binary_range_encoder #(
	parameter int PROB_ENTRIES = abre_pkg::PROB_ENTRIES_DEF,
	parameter int PROB_BITS    = abre_pkg::PROB_BITS_DEF,
	parameter int ADAPT_SHIFT  = abre_pkg::ADAPT_SHIFT_DEF
) (
	input logic         clk,
	input logic         arst_n,
	abre_in_if.sink     item,
	abre_out_if.source  result
);

	abre_pkg::ctl_t ctl;
	abre_pkg::sts_t sts;

	abre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_cmd   (item.cmd),
		.in_ready (item.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	abre_dp #(
		.PROB_ENTRIES (PROB_ENTRIES),
		.PROB_BITS    (PROB_BITS),
		.ADAPT_SHIFT  (ADAPT_SHIFT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (item.cmd),
		.prob_index   (item.prob_index),
		.bit_value    (item.bit_value),
		.direct_value (item.direct_value),
		.direct_count (item.direct_count),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.lead_byte    (result.lead_byte),
		.fill_byte    (result.fill_byte),
		.fill_count   (result.fill_count),
		.flush_done   (result.flush_done)
	);

endmodule

// ===== tb/tb_adaptive_binary_range_encoder.sv =====
// Self-checking testbench for the adaptive binary range encoder with a byte-run predictor.
`timescale 1ns / 1ps

typedef struct packed {
	logic [7:0]  lead;
	logic [7:0]  fill;
	logic [31:0] count;
	logic        done;
} run_word_t;

class byte_run_tracker;
	localparam int PROB_N   = abre_pkg::PROB_ENTRIES_DEF;
	localparam int PBITS    = abre_pkg::PROB_BITS_DEF;
	localparam int ADAPT    = abre_pkg::ADAPT_SHIFT_DEF;
	localparam int PROB_ONE = 1 << PBITS;

	logic [32:0]      lo;
	logic [31:0]      rng;
	logic [7:0]       cache;
	logic [31:0]      pend;
	logic [PBITS-1:0] prob_mem [PROB_N];
	run_word_t        expected_runs[$];
	int               mismatches;

	function new();
		mismatches = 0;
		restart();
	endfunction

	function void restart();
		lo    = '0;
		rng   = 32'hFFFF_FFFF;
		cache = '0;
		pend  = 32'd1;
		for (int i = 0; i < PROB_N; i++)
			prob_mem[i] = PBITS'(PROB_ONE >> 1);
	endfunction

	function void shift_out();
		logic        carry;
		logic [31:0] low32;
		run_word_t   w;
		carry = lo[32];
		low32 = lo[31:0];
		if (low32 < 32'hFF00_0000 || carry) begin
			w.lead  = cache + {7'd0, carry};
			w.fill  = 8'hFF + {7'd0, carry};
			w.count = (pend != 0) ? pend - 32'd1 : 32'd0;
			w.done  = 1'b0;
			expected_runs.push_back(w);
			cache = low32[31:24];
			pend  = '0;
		end
		if (pend != 32'hFFFF_FFFF)
			pend = pend + 32'd1;
		lo = {1'b0, low32[23:0], 8'h00};
	endfunction

	function void renorm();
		if (rng < 32'h0100_0000) begin
			rng = rng << 8;
			shift_out();
		end
	endfunction

	function void code_word(abre_pkg::cmd_t cmd, logic [12:0] idx, logic bv,
		logic [25:0] dval, logic [4:0] dcnt);
		int          pi;
		int          n;
		int          runs_prior;
		logic [31:0] bound;
		case (cmd)
			abre_pkg::CMD_BIT: begin
				pi    = int'(prob_mem[idx]);
				bound = (rng >> PBITS) * 32'(pi);
				if (!bv) begin
					rng = bound;
					pi  = pi + ((PROB_ONE - pi) >> ADAPT);
				end else begin
					lo  = lo + {1'b0, bound};
					rng = rng - bound;
					pi  = pi - (pi >> ADAPT);
				end
				prob_mem[idx] = PBITS'(pi);
				renorm();
			end
			abre_pkg::CMD_DIRECT: begin
				n = (dcnt > abre_pkg::DIRECT_MAX) ? int'(abre_pkg::DIRECT_MAX) : int'(dcnt);
				for (int i = n; i > 0; i--) begin
					rng = rng >> 1;
					if (dval[i-1])
						lo = lo + {1'b0, rng};
					renorm();
				end
			end
			abre_pkg::CMD_FLUSH: begin
				runs_prior = expected_runs.size();
				repeat (int'(abre_pkg::FLUSH_SHIFTS)) shift_out();
				if (expected_runs.size() > runs_prior)
					expected_runs[expected_runs.size()-1].done = 1'b1;
			end
			default: restart();
		endcase
	endfunction

	function void match_run(logic [7:0] lead, logic [7:0] fill, logic [31:0] count, logic done);
		run_word_t want;
		if (expected_runs.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: lead %h fill %h count %0d done %b",
					lead, fill, count, done);
			return;
		end
		want = expected_runs.pop_front();
		if (lead !== want.lead || fill !== want.fill || count !== want.count ||
			done !== want.done) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp lead %h fill %h count %0d done %b, ",
					want.lead, want.fill, want.count, want.done,
					"got lead %h fill %h count %0d done %b", lead, fill, count, done);
		end
	endfunction
endclass

module tb_adaptive_binary_range_encoder;

	logic clk;
	logic arst_n;
	int   src_idle;
	int   rcv_idle;

	abre_in_if  item ();
	abre_out_if result ();

	byte_run_tracker coder = new();

	adaptive_binary_range_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && item.valid && item.ready)
			coder.code_word(abre_pkg::cmd_t'(item.cmd), item.prob_index, item.bit_value,
				item.direct_value, item.direct_count);
		if (arst_n && result.valid && result.ready)
			coder.match_run(result.lead_byte, result.fill_byte, result.fill_count,
				result.flush_done);
	end

	always @(negedge clk)
		result.ready <= (rcv_idle == 0) ? 1'b1 : ($urandom_range(0, 99) >= rcv_idle);

	// called and returns at a falling edge with no pending update to valid
	task automatic push_word(abre_pkg::cmd_t cmd, logic [12:0] idx, logic bv,
		logic [25:0] dval, logic [4:0] dcnt);
		while ($urandom_range(0, 99) < src_idle) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.valid        <= 1'b1;
		item.cmd          <= cmd;
		item.prob_index   <= idx;
		item.bit_value    <= bv;
		item.direct_value <= dval;
		item.direct_count <= dcnt;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_runs();
		item.valid <= 1'b0;
		do
			@(negedge clk);
		while (coder.expected_runs.size() != 0);
	endtask

	task automatic random_word();
		int          r;
		logic [12:0] idx;
		logic [4:0]  cnt;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			// mostly a small set of contexts so the probabilities adapt far
			idx = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
				: 13'($urandom_range(0, 15));
			push_word(abre_pkg::CMD_BIT, idx, $urandom_range(0, 99) < (idx[0] ? 85 : 15),
				26'($urandom()), 5'($urandom()));
		end else if (r < 85) begin
			cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(1, 26));
			push_word(abre_pkg::CMD_DIRECT, 13'($urandom()), 1'($urandom()),
				26'($urandom()), cnt);
		end else if (r < 98) begin
			push_word(abre_pkg::CMD_FLUSH, 13'($urandom()), 1'($urandom()),
				26'($urandom()), 5'($urandom()));
		end else begin
			push_word(abre_pkg::CMD_START, 13'($urandom()), 1'($urandom()),
				26'($urandom()), 5'($urandom()));
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		src_idle          = 11;
		rcv_idle          = 59;
		item.valid        = 1'b0;
		item.cmd          = abre_pkg::CMD_BIT;
		item.prob_index   = '0;
		item.bit_value    = 1'b0;
		item.direct_value = '0;
		item.direct_count = '0;
		result.ready      = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_word(abre_pkg::CMD_BIT, 13'd0, 1'b0, 26'd0, 5'd0);
		push_word(abre_pkg::CMD_BIT, 13'h1FFF, 1'b1, 26'h3FF_FFFF, 5'h1F);
		push_word(abre_pkg::CMD_BIT, 13'h1FFF, 1'b1, 26'd0, 5'd0);
		push_word(abre_pkg::CMD_BIT, 13'h1000, 1'b0, 26'd0, 5'd0);
		push_word(abre_pkg::CMD_DIRECT, 13'd0, 1'b0, 26'h3FF_FFFF, 5'd26);
		push_word(abre_pkg::CMD_DIRECT, 13'd0, 1'b0, 26'h3FF_FFFF, 5'd26);
		push_word(abre_pkg::CMD_DIRECT, 13'd0, 1'b0, 26'h3FF_FFFF, 5'd26);
		push_word(abre_pkg::CMD_BIT, 13'd5, 1'b1, 26'd0, 5'd0);
		push_word(abre_pkg::CMD_DIRECT, 13'd0, 1'b0, 26'd0, 5'd26);
		push_word(abre_pkg::CMD_DIRECT, 13'd0, 1'b0, 26'h155_5555, 5'd0);
		push_word(abre_pkg::CMD_DIRECT, 13'd0, 1'b0, 26'h2AA_AAAA, 5'd31);
		push_word(abre_pkg::CMD_DIRECT, 13'd0, 1'b0, 26'h155_5555, 5'd27);
		push_word(abre_pkg::CMD_DIRECT, 13'd0, 1'b0, 26'd1, 5'd1);
		push_word(abre_pkg::CMD_FLUSH, 13'd0, 1'b0, 26'd0, 5'd0);
		push_word(abre_pkg::CMD_BIT, 13'h0AAA, 1'b1, 26'd0, 5'd0);
		push_word(abre_pkg::CMD_BIT, 13'h1555, 1'b0, 26'd0, 5'd0);
		push_word(abre_pkg::CMD_START, 13'd0, 1'b0, 26'd0, 5'd0);
		push_word(abre_pkg::CMD_FLUSH, 13'd0, 1'b0, 26'd0, 5'd0);
		push_word(abre_pkg::CMD_FLUSH, 13'd0, 1'b0, 26'd0, 5'd0);
		push_word(abre_pkg::CMD_START, 13'h1FFF, 1'b1, 26'h3FF_FFFF, 5'h1F);
		push_word(abre_pkg::CMD_BIT, 13'h1FFF, 1'b0, 26'd0, 5'd0);

		repeat (137) random_word();
		drain_runs();
		src_idle = 59;
		rcv_idle = 11;
		repeat (137) random_word();
		src_idle = 0;
		rcv_idle = 0;
		repeat (136) random_word();

		drain_runs();
		repeat (64) @(posedge clk);
		if (coder.mismatches == 0 && coder.expected_runs.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
